/* src/maqs_pkg.sv */
// ----------------------------------------------------------------------------
// maqs_pkg
// Shared types and constants for the motor action queue sequencer.
// ----------------------------------------------------------------------------
package maqs_pkg;

    localparam int OP_W    = 3;
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 32;
    localparam int DT_W    = 16;
    localparam int CNT_W   = 5;
    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 40;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_PUSH      = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_SET_POS   = 3'd3,
        OP_SET_SPEED = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEL    = 2'd0,
        KIND_MOVE_TO  = 2'd1,
        KIND_MOVE_BY  = 2'd2,
        KIND_RUN_TIME = 2'd3
    } t_kind;

    // move direction latch values held in the counter field
    localparam logic [DATA_W-1:0] DIR_NONE = 32'd0;
    localparam logic [DATA_W-1:0] DIR_FWD  = 32'd1;
    localparam logic [DATA_W-1:0] DIR_BWD  = 32'd2;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  accel;
        logic [DATA_W-1:0]  speed;
        logic [DATA_W-1:0]  goal;
        logic [DATA_W-1:0]  counter;
    } t_entry;

endpackage

/* src/motor_action_queue_sequencer_top.sv */
// ----------------------------------------------------------------------------
// motor_action_queue_sequencer_top
// Ring queue of motor actions with speed ramping, moves and timed runs.
// ----------------------------------------------------------------------------
// An item passes through the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled, set by the update
// of the head slot and the prefetch of the next head from slot memory.
// Reset (sync, active low): queue empty, speed and position zero,
// queue_limit 16. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module motor_action_queue_sequencer_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_wdata,     // queue_limit
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [15:0] dt, [47:16] value, [49:48] action_type, [81:50] action_accel,
    // [113:82] action_speed, [145:114] action_target, [177:146] action_tick
    input  logic [183:0] i_s_axis_tdata,
    input  logic [2:0]   i_s_axis_tuser,  // [2:0] operation
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] speed_out, [32] speed_write, [37:33] queue_count,
    // [38] push_dropped, [39] action_finished
    output logic [39:0]  o_m_axis_tdata
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = maqs_pkg::CNT_W;
    localparam int LIM_MAX = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;
    localparam int AW      = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    // input register
    logic                        r_in_valid;
    logic [2:0]                  r_op;
    logic [15:0]                 r_dt;
    logic [31:0]                 r_value;
    maqs_pkg::t_entry            r_push;

    // state
    logic [CNT_W-1:0]            r_limit;
    logic [31:0]                 r_speed;
    logic [31:0]                 r_position;
    logic [IDX_W-1:0]            r_head;
    logic [IDX_W-1:0]            r_tail;
    logic [CNT_W-1:0]            r_count;

    // result register
    logic                        r_out_valid;
    logic [39:0]                 r_out_data;

    logic                        adv;
    logic [CNT_W-1:0]            lim;
    maqs_pkg::t_entry            head_e;

    logic [31:0]                 n_speed;
    logic [31:0]                 n_position;
    logic [IDX_W-1:0]            n_head;
    logic [IDX_W-1:0]            n_tail;
    logic [CNT_W-1:0]            n_count;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    maqs_pkg::t_entry            wr_data;
    logic [31:0]                 cmd;
    logic                        cmd_wr;
    logic                        dropped;
    logic                        finished;

    function automatic logic [IDX_W-1:0] f_advance(
        input logic [IDX_W-1:0] idx,
        input logic [CNT_W-1:0] lim_v
    );
        logic [AW-1:0] nxt;
        nxt = AW'(idx) + AW'(1);
        if (nxt >= AW'(lim_v)) begin
            return '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        if (r_limit == '0) begin
            lim = CNT_W'(1);
        end else if (int'(r_limit) > LIM_MAX) begin
            lim = CNT_W'(LIM_MAX);
        end else begin
            lim = r_limit;
        end
    end

    maqs_queue_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_head),     // prefetch the head seen by the next item
        .o_rd_data (head_e)
    );

    always_comb begin
        logic [31:0]      ramp;
        logic [31:0]      spd;
        logic [31:0]      goal;
        logic [31:0]      ctr;
        logic             done;
        logic             pop;
        logic [CNT_W-1:0] cnt_pop;

        ramp     = r_speed + head_e.accel * {16'd0, r_dt};
        spd      = r_speed;
        goal     = head_e.goal;
        ctr      = head_e.counter;
        done     = 1'b0;
        pop      = 1'b0;
        cnt_pop  = r_count - CNT_W'(1);

        n_speed    = r_speed;
        n_position = r_position;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        wr_data    = r_push;
        cmd        = '0;
        cmd_wr     = 1'b0;
        dropped    = 1'b0;
        finished   = 1'b0;

        if (adv) begin
            unique case (maqs_pkg::t_op'(r_op))
                maqs_pkg::OP_TICK: begin
                    if (r_count != '0) begin
                        if (r_speed != head_e.speed) begin
                            spd    = ramp;
                            cmd    = ramp;
                            cmd_wr = 1'b1;
                        end
                        n_speed = spd;
                        case (head_e.kind)
                            maqs_pkg::KIND_ACCEL: begin
                                // exact equality only
                                pop = (spd == head_e.speed);
                            end
                            maqs_pkg::KIND_MOVE_TO, maqs_pkg::KIND_MOVE_BY: begin
                                if (head_e.counter == maqs_pkg::DIR_NONE) begin
                                    if (head_e.kind == maqs_pkg::KIND_MOVE_BY) begin
                                        goal = head_e.goal + r_position;
                                    end
                                    ctr = ($signed(r_position) < $signed(goal)) ?
                                          maqs_pkg::DIR_FWD : maqs_pkg::DIR_BWD;
                                end
                                done = ((ctr == maqs_pkg::DIR_FWD) &&
                                        ($signed(r_position) >= $signed(goal))) ||
                                       ((ctr == maqs_pkg::DIR_BWD) &&
                                        ($signed(r_position) <= $signed(goal)));
                            end
                            default: begin
                                if (head_e.counter > {16'd0, r_dt}) begin
                                    ctr = head_e.counter - {16'd0, r_dt};
                                end else begin
                                    done = 1'b1;
                                end
                            end
                        endcase
                        // write back latched direction, goal and countdown
                        if (head_e.kind != maqs_pkg::KIND_ACCEL) begin
                            wr_en           = 1'b1;
                            wr_addr         = r_head;
                            wr_data         = head_e;
                            wr_data.goal    = goal;
                            wr_data.counter = ctr;
                        end
                        if (pop || done) begin
                            finished = 1'b1;
                            n_count  = cnt_pop;
                            n_head   = f_advance(r_head, lim);
                        end
                        // draining the queue on a finished move or run stops the motor
                        if (done && (cnt_pop == '0)) begin
                            cmd    = '0;
                            cmd_wr = 1'b1;
                        end
                    end
                end
                maqs_pkg::OP_PUSH: begin
                    if (r_count >= lim) begin
                        dropped = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_tail;
                        wr_data = r_push;
                        n_count = r_count + CNT_W'(1);
                        n_tail  = f_advance(r_tail, lim);
                    end
                end
                maqs_pkg::OP_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    cmd_wr  = 1'b1;
                end
                maqs_pkg::OP_SET_POS: begin
                    n_position = r_value;
                end
                maqs_pkg::OP_SET_SPEED: begin
                    n_speed = r_value;
                    cmd     = r_value;
                    cmd_wr  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= maqs_pkg::LIMIT_RESET;
            r_speed     <= '0;
            r_position  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_speed    <= n_speed;
            r_position <= n_position;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_op           <= i_s_axis_tuser;
            r_dt           <= i_s_axis_tdata[15:0];
            r_value        <= i_s_axis_tdata[47:16];
            r_push.kind    <= maqs_pkg::t_kind'(i_s_axis_tdata[49:48]);
            r_push.accel   <= i_s_axis_tdata[81:50];
            r_push.speed   <= i_s_axis_tdata[113:82];
            r_push.goal    <= i_s_axis_tdata[145:114];
            r_push.counter <= i_s_axis_tdata[177:146];
        end
        if (adv) begin
            r_out_data <= {finished, dropped, n_count, cmd_wr, cmd};
        end
    end

endmodule

/* src/maqs_queue_mem.sv */
// ----------------------------------------------------------------------------
// maqs_queue_mem
// Action slot memory: one write port, one registered read port with
// write-to-read bypass so a slot written on the same edge reads back new data.
// ----------------------------------------------------------------------------
module maqs_queue_mem #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_addr,
    input  maqs_pkg::t_entry               i_wr_data,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rd_addr,
    output maqs_pkg::t_entry               o_rd_data
);

    maqs_pkg::t_entry mem [QUEUE_DEPTH];
    maqs_pkg::t_entry r_rd_data;
    maqs_pkg::t_entry r_byp_data;
    logic             r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= mem[i_rd_addr];
        r_byp_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp_hit ? r_byp_data : r_rd_data;

endmodule
